### design/dcrf_pkg.sv
// shared types and decode constants for the display controller register file
`default_nettype none

package dcrf_pkg;

  localparam logic ActWrite = 1'b0;
  localparam logic ActRead  = 1'b1;

  localparam logic [7:0] AddrGate    = 8'h08;
  localparam logic [7:0] AddrMode    = 8'hCE;
  localparam logic [7:0] AddrBorder  = 8'hCF;
  localparam logic [7:0] AddrPalette = 8'hF0;
  localparam logic [7:0] BorderPage  = 8'h06;

  localparam int unsigned GroupSelBit = 6;
  localparam int unsigned ModeLegacy  = 3;
  localparam logic [2:0]  AliasBits   = 3'b111;

  localparam logic [3:0] ModeReset   = 4'h8;
  localparam logic [3:0] BorderReset = 4'h0;
  localparam logic [1:0] GroupReset  = 2'd0;
  localparam logic [3:0] PalEvenReset = 4'h9;
  localparam logic [3:0] PalOddReset  = 4'hF;

  typedef logic [3:0] colour_t;

  typedef struct packed {
    logic        action;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic        hblank;
    logic        vblank;
    logic        hsync_status;
    logic        vsync_status;
    logic        tempo;
    logic        mode_switch;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [3:0] display_mode;
    colour_t    border_color;
    logic [1:0] palette_group;
    colour_t    palette_zero;
    colour_t    palette_one;
    colour_t    palette_two;
    colour_t    palette_three;
    logic       gate_level;
    logic       gate_changed;
    logic       screen_changed;
    logic       border_changed;
  } out_item_t;

endpackage

`default_nettype wire

### design/dcrf_in_if.sv
// request channel into the register file
`default_nettype none

interface dcrf_in_if;
  import dcrf_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### design/dcrf_out_if.sv
// result channel out of the register file
`default_nettype none

interface dcrf_out_if;
  import dcrf_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### design/display_controller_register_file_top.sv
// display controller register file: bus decode, registers and result register
//
//   channel  dir  handshake     carries
//   in_bus   in   valid/ready   one bus request (write or status read)
//   out_bus  out  valid/ready   status byte, register contents, change flags
//
// one request per cycle while no result waits or out_bus is ready; its result
// is captured in the output register on the accepting edge. registers update on
// that edge, so a following request sees them at once. synchronous active-low
// reset restores the power-up register values and empties the output register.
// in_bus stalls only while a result is held and out_bus is not ready.
`default_nettype none

module display_controller_register_file_top (
  input wire logic clk,
  input wire logic rst_n,
  dcrf_in_if.sink  in_bus,
  dcrf_out_if.source out_bus
);
  import dcrf_pkg::*;

  logic [3:0] mode_r, mode_nxt;
  colour_t    border_r, border_nxt;
  logic [1:0] group_r, group_nxt;
  colour_t    pal_r [4];
  colour_t    pal_nxt [4];
  logic       gate_r, gate_nxt;

  out_item_t  out_r, out_nxt;
  logic       out_valid_r;

  logic       accept;
  in_item_t   req;
  logic [7:0] addr_lo;
  logic [7:0] addr_hi;
  logic       legacy;
  logic       alias_on;
  logic [1:0] idx;
  colour_t    colour;
  logic       gch, sch, bch, pal_changed;

  assign in_bus.ready = !out_valid_r || out_bus.ready;
  assign accept       = in_bus.valid && in_bus.ready;
  assign req          = in_bus.payload;
  assign addr_lo      = req.address[7:0];
  assign addr_hi      = req.address[15:8];
  assign legacy       = mode_r[ModeLegacy];
  assign alias_on     = (mode_r[2:0] == AliasBits);
  assign idx          = req.write_data[5:4];
  assign colour       = req.write_data[3:0];

  always_comb begin
    mode_nxt    = mode_r;
    border_nxt  = border_r;
    group_nxt   = group_r;
    gate_nxt    = gate_r;
    pal_nxt     = pal_r;
    gch         = 1'b0;
    sch         = 1'b0;
    bch         = 1'b0;
    pal_changed = 1'b0;
    if (req.action == ActWrite) begin
      case (addr_lo)
        AddrGate: begin
          gate_nxt = req.write_data[0];
          gch      = (gate_nxt != gate_r);
        end
        AddrMode: begin
          mode_nxt = req.write_data[3:0];
          sch      = (mode_nxt != mode_r);
        end
        AddrBorder: begin
          if (addr_hi == BorderPage) begin
            border_nxt = req.write_data[3:0];
            bch        = (border_nxt != border_r);
          end
        end
        AddrPalette: begin
          if (req.write_data[GroupSelBit]) begin
            group_nxt   = req.write_data[1:0];
            pal_changed = (group_nxt != group_r);
          end else begin
            pal_nxt[idx] = colour;
            // undocumented alias: outer entries mirror into inner ones
            if (alias_on && idx == 2'd0) begin
              pal_nxt[1] = colour;
            end else if (alias_on && idx == 2'd3) begin
              pal_nxt[2] = colour;
            end
            pal_changed = (pal_nxt[0] != pal_r[0]) || (pal_nxt[1] != pal_r[1])
                       || (pal_nxt[2] != pal_r[2]) || (pal_nxt[3] != pal_r[3]);
          end
          sch = pal_changed && !legacy;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_nxt                = '0;
    if (req.action == ActRead) begin
      out_nxt.read_data = {req.hblank, req.vblank, req.hsync_status, req.vsync_status,
                           2'b00, req.mode_switch, req.tempo};
    end
    out_nxt.display_mode   = mode_nxt;
    out_nxt.border_color   = border_nxt;
    out_nxt.palette_group  = group_nxt;
    out_nxt.palette_zero   = pal_nxt[0];
    out_nxt.palette_one    = pal_nxt[1];
    out_nxt.palette_two    = pal_nxt[2];
    out_nxt.palette_three  = pal_nxt[3];
    out_nxt.gate_level     = gate_nxt;
    out_nxt.gate_changed   = gch;
    out_nxt.screen_changed = sch;
    out_nxt.border_changed = bch;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= ModeReset;
      border_r    <= BorderReset;
      group_r     <= GroupReset;
      gate_r      <= 1'b0;
      pal_r[0]    <= PalEvenReset;
      pal_r[1]    <= PalOddReset;
      pal_r[2]    <= PalEvenReset;
      pal_r[3]    <= PalOddReset;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        mode_r   <= mode_nxt;
        border_r <= border_nxt;
        group_r  <= group_nxt;
        gate_r   <= gate_nxt;
        pal_r    <= pal_nxt;
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= out_nxt;
    end
  end

  assign out_bus.valid   = out_valid_r;
  assign out_bus.payload = out_r;

  // status reads leave every register alone
  a_read_no_update: assert property (@(posedge clk) disable iff (!rst_n)
    accept && req.action == ActRead |=>
      $stable(mode_r) && $stable(border_r) && $stable(group_r) && $stable(gate_r))
    else $error("status read altered a register");

  // each address drives at most one change flag, so at most one flag per request
  a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $countones({out_r.gate_changed, out_r.screen_changed,
                                out_r.border_changed}) <= 1)
    else $error("more than one change flag raised");

  // gate flag tracks an actual change of the gate register
  a_gate_flag: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_r.gate_changed == (gate_r != $past(gate_r)))
    else $error("gate flag disagrees with gate register");

  // border flag tracks an actual change of the border register
  a_border_flag: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_r.border_changed == (border_r != $past(border_r)))
    else $error("border flag disagrees with border register");

  // result shows the registers as left by its own request
  a_result_state: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_r.display_mode == mode_r && out_r.palette_group == group_r)
    else $error("result does not match register contents");

endmodule

`default_nettype wire
